FILE: hw/rtl/psmrl_pkg.sv
// Package for the per-source message rate limiter.
// Holds the shared types, codes and reset values; depends on nothing.
`default_nettype none

package psmrl_pkg;

  // Default number of tracked sources.
  localparam int TABLE_DEPTH_DEFAULT = 32;

  // Field widths.
  localparam int NODE_W   = 32;
  localparam int TIME_W   = 32;
  localparam int KIND_W   = 2;
  localparam int REASON_W = 2;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIDGE_NODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_ENABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEL_ENABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_MIN_GAP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEL_MIN_GAP  = 3'd5;

  // Message kinds.
  localparam logic [KIND_W-1:0] KIND_TEXT      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POSITION  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TELEMETRY = 2'd2;

  // Drop reasons.
  localparam logic [REASON_W-1:0] REASON_FORWARD  = 2'd0;
  localparam logic [REASON_W-1:0] REASON_ECHO     = 2'd1;
  localparam logic [REASON_W-1:0] REASON_DISABLED = 2'd2;
  localparam logic [REASON_W-1:0] REASON_LIMITED  = 2'd3;

  // Reset value of both minimum gaps.
  localparam logic [TIME_W-1:0] MIN_GAP_RESET = 32'd60000;

  // Register file contents.
  typedef struct packed {
    logic [NODE_W-1:0] own_node_id;
    logic [NODE_W-1:0] bridge_node_id;
    logic              position_enable;
    logic              telemetry_enable;
    logic [TIME_W-1:0] position_min_gap_ms;
    logic [TIME_W-1:0] telemetry_min_gap_ms;
  } cfg_t;

  // One node table entry as stored in the memory.
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [TIME_W-1:0] last_position;
    logic [TIME_W-1:0] last_telemetry;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One decision.
  typedef struct packed {
    logic                forward;
    logic [REASON_W-1:0] drop_reason;
    logic                untracked;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/psmrl_in_if.sv
// Input channel of the rate limiter: one parsed message per beat.
// Depends on psmrl_pkg for the field widths.
`default_nettype none

interface psmrl_in_if;
  logic                              valid;
  logic                              ready;
  logic [psmrl_pkg::NODE_W-1:0]      source_node;
  logic [psmrl_pkg::KIND_W-1:0]      message_kind;
  logic [psmrl_pkg::TIME_W-1:0]      now_ms;

  modport source (output valid, source_node, message_kind, now_ms, input ready);
  modport sink   (input valid, source_node, message_kind, now_ms, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/psmrl_out_if.sv
// Result channel of the rate limiter: one decision per beat.
// Depends on psmrl_pkg for the field widths.
`default_nettype none

interface psmrl_out_if;
  logic                              valid;
  logic                              ready;
  logic                              forward;
  logic [psmrl_pkg::REASON_W-1:0]    drop_reason;
  logic                              untracked;

  modport source (output valid, forward, drop_reason, untracked, input ready);
  modport sink   (input valid, forward, drop_reason, untracked, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/psmrl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module psmrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/psmrl_cfg.sv
// Configuration registers of the rate limiter, written through a plain write port.
// Depends on psmrl_pkg for the register indexes and the cfg_t type.
`default_nettype none

module psmrl_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [psmrl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [psmrl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output psmrl_pkg::cfg_t                          cfg
);

  psmrl_pkg::cfg_t cfg_r;
  psmrl_pkg::cfg_t cfg_nxt;

  // Decode the register index; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        psmrl_pkg::REG_OWN_NODE:    cfg_nxt.own_node_id          = cfg_wdata;
        psmrl_pkg::REG_BRIDGE_NODE: cfg_nxt.bridge_node_id       = cfg_wdata;
        psmrl_pkg::REG_POS_ENABLE:  cfg_nxt.position_enable      = cfg_wdata[0];
        psmrl_pkg::REG_TEL_ENABLE:  cfg_nxt.telemetry_enable     = cfg_wdata[0];
        psmrl_pkg::REG_POS_MIN_GAP: cfg_nxt.position_min_gap_ms  = cfg_wdata;
        psmrl_pkg::REG_TEL_MIN_GAP: cfg_nxt.telemetry_min_gap_ms = cfg_wdata;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_node_id          <= '0;
      cfg_r.bridge_node_id       <= '0;
      cfg_r.position_enable      <= 1'b1;
      cfg_r.telemetry_enable     <= 1'b1;
      cfg_r.position_min_gap_ms  <= psmrl_pkg::MIN_GAP_RESET;
      cfg_r.telemetry_min_gap_ms <= psmrl_pkg::MIN_GAP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: hw/rtl/psmrl_engine.sv
// Decision engine: echo and kind checks, node table search, time check and write-back.
// Depends on psmrl_pkg and psmrl_in_if; the node table lives in an external psmrl_ram.
`default_nettype none

module psmrl_engine #(
  parameter int TABLE_DEPTH = psmrl_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire psmrl_pkg::cfg_t                         cfg,
  psmrl_in_if.sink                                     in_ch,
  // Finished decision towards the output register.
  output logic                                         res_valid,
  output psmrl_pkg::res_t                              res,
  input  wire logic                                    res_take,
  // Node table memory.
  output logic                                         ram_we,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_waddr,
  output logic [psmrl_pkg::ENTRY_W-1:0]                ram_wdata,
  output logic                                         ram_re,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_raddr,
  input  wire logic [psmrl_pkg::ENTRY_W-1:0]           ram_rdata
);

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_ADD,
    S_RESULT
  } state_t;

  state_t                           state_r, state_nxt;
  logic [CNT_W-1:0]                 used_r, used_nxt;
  logic [CNT_W-1:0]                 scan_r, scan_nxt;
  logic                             cmp_valid_r, cmp_valid_nxt;
  logic [AW-1:0]                    cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]                    hit_idx_r, hit_idx_nxt;
  psmrl_pkg::entry_t                entry_r, entry_nxt;
  logic [psmrl_pkg::NODE_W-1:0]     src_r, src_nxt;
  logic                             is_pos_r, is_pos_nxt;
  logic [psmrl_pkg::TIME_W-1:0]     now_r, now_nxt;
  psmrl_pkg::res_t                  res_r, res_nxt;

  psmrl_pkg::entry_t                rd_entry;
  psmrl_pkg::entry_t                wr_entry;
  logic                             in_is_pos;
  logic                             in_is_tbl;
  logic                             in_enabled;
  logic                             issue;
  logic                             match;
  logic [psmrl_pkg::TIME_W-1:0]     slot;
  logic [psmrl_pkg::TIME_W-1:0]     gap;
  logic [psmrl_pkg::TIME_W-1:0]     elapsed;

  assign rd_entry = psmrl_pkg::entry_t'(ram_rdata);

  // Classification of the beat on the input channel.
  assign in_is_pos  = (in_ch.message_kind == psmrl_pkg::KIND_POSITION);
  assign in_is_tbl  = in_is_pos || (in_ch.message_kind == psmrl_pkg::KIND_TELEMETRY);
  assign in_enabled = in_is_pos ? cfg.position_enable : cfg.telemetry_enable;

  // Search pipeline: one read issued per cycle, compared in the next cycle.
  assign issue = (state_r == S_SEARCH) && (scan_r < used_r);
  assign match = cmp_valid_r && (rd_entry.node == src_r);

  // Time check on the entry that was found.
  assign slot    = is_pos_r ? entry_r.last_position : entry_r.last_telemetry;
  assign gap     = is_pos_r ? cfg.position_min_gap_ms : cfg.telemetry_min_gap_ms;
  assign elapsed = now_r - slot;

  assign in_ch.ready = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_RESULT);
  assign res         = res_r;

  assign ram_re    = issue;
  assign ram_raddr = scan_r[AW-1:0];

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    scan_nxt      = scan_r;
    cmp_valid_nxt = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    hit_idx_nxt   = hit_idx_r;
    entry_nxt     = entry_r;
    src_nxt       = src_r;
    is_pos_nxt    = is_pos_r;
    now_nxt       = now_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = hit_idx_r;
    wr_entry      = entry_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          src_nxt           = in_ch.source_node;
          is_pos_nxt        = in_is_pos;
          now_nxt           = in_ch.now_ms;
          scan_nxt          = '0;
          res_nxt.forward   = 1'b0;
          res_nxt.untracked = 1'b0;
          state_nxt         = S_RESULT;
          priority if ((cfg.own_node_id != '0) && (in_ch.source_node == cfg.own_node_id)) begin
            res_nxt.drop_reason = psmrl_pkg::REASON_ECHO;
          end else if ((cfg.bridge_node_id != '0) &&
                       (in_ch.source_node == cfg.bridge_node_id)) begin
            res_nxt.drop_reason = psmrl_pkg::REASON_ECHO;
          end else if (!in_is_tbl) begin
            res_nxt.forward     = 1'b1;
            res_nxt.drop_reason = psmrl_pkg::REASON_FORWARD;
          end else if (!in_enabled) begin
            res_nxt.drop_reason = psmrl_pkg::REASON_DISABLED;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        if (issue) begin
          scan_nxt      = scan_r + CNT_W'(1);
          cmp_valid_nxt = 1'b1;
          cmp_idx_nxt   = scan_r[AW-1:0];
        end
        if (match) begin
          entry_nxt     = rd_entry;
          hit_idx_nxt   = cmp_idx_r;
          cmp_valid_nxt = 1'b0;
          state_nxt     = S_UPDATE;
        end else if (!issue) begin
          if (used_r < CNT_W'(TABLE_DEPTH)) begin
            state_nxt = S_ADD;
          end else begin
            // Unknown source and no room: passed on without a limit.
            res_nxt.forward     = 1'b1;
            res_nxt.drop_reason = psmrl_pkg::REASON_FORWARD;
            res_nxt.untracked   = 1'b1;
            state_nxt           = S_RESULT;
          end
        end
      end

      S_UPDATE: begin
        // A stored time of zero means the kind was never forwarded.
        if ((slot != '0) && (elapsed < gap)) begin
          res_nxt.forward     = 1'b0;
          res_nxt.drop_reason = psmrl_pkg::REASON_LIMITED;
        end else begin
          res_nxt.forward     = 1'b1;
          res_nxt.drop_reason = psmrl_pkg::REASON_FORWARD;
          ram_we              = 1'b1;
          ram_waddr           = hit_idx_r;
          if (is_pos_r) begin
            wr_entry.last_position = now_r;
          end else begin
            wr_entry.last_telemetry = now_r;
          end
        end
        state_nxt = S_RESULT;
      end

      S_ADD: begin
        // A fresh entry always forwards, so its time is stored at once.
        ram_we                  = 1'b1;
        ram_waddr               = used_r[AW-1:0];
        wr_entry.node           = src_r;
        wr_entry.last_position  = is_pos_r ? now_r : '0;
        wr_entry.last_telemetry = is_pos_r ? '0 : now_r;
        used_nxt                = used_r + CNT_W'(1);
        res_nxt.forward         = 1'b1;
        res_nxt.drop_reason     = psmrl_pkg::REASON_FORWARD;
        state_nxt               = S_RESULT;
      end

      S_RESULT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ram_wdata = wr_entry;

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      cmp_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cmp_valid_r <= cmp_valid_nxt;
    end
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    entry_r   <= entry_nxt;
    src_r     <= src_nxt;
    is_pos_r  <= is_pos_nxt;
    now_r     <= now_nxt;
    res_r     <= res_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/per_source_message_rate_limiter.sv
// Per-source message rate limiter. One message is handled at a time. Echo, text and
// disabled-kind messages are decided at acceptance and go straight to the result state;
// position and telemetry messages scan the node table held in one single-port-read
// RAM at one entry per cycle, stopping at a match or after the last entry in use. The
// next message can be accepted as soon as the result has moved to the output register,
// so the scan through that RAM read port sets the rate unless the output stalls. A new
// message is taken while the previous result still waits in the output register. No
// clearing pass is needed after reset.
// Top level; depends on psmrl_pkg, psmrl_in_if, psmrl_out_if, psmrl_cfg,
// psmrl_ram and psmrl_engine.
`default_nettype none

module per_source_message_rate_limiter #(
  parameter int TABLE_DEPTH = psmrl_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  psmrl_in_if.sink                               in_ch,
  psmrl_out_if.source                            out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [psmrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [psmrl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  psmrl_pkg::cfg_t                  cfg;
  logic                             res_valid;
  psmrl_pkg::res_t                  res;
  logic                             res_take;
  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [psmrl_pkg::ENTRY_W-1:0]    ram_wdata;
  logic                             ram_re;
  logic [AW-1:0]                    ram_raddr;
  logic [psmrl_pkg::ENTRY_W-1:0]    ram_rdata;

  logic                             out_valid_r, out_valid_nxt;
  psmrl_pkg::res_t                  out_res_r, out_res_nxt;

  // Configuration registers.
  psmrl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Node table.
  psmrl_ram #(
    .WIDTH (psmrl_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decision sequencer.
  psmrl_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Output register: loads a decision whenever it is empty or being emptied.
  assign res_take = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_take) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.forward     = out_res_r.forward;
  assign out_ch.drop_reason = out_res_r.drop_reason;
  assign out_ch.untracked   = out_res_r.untracked;

endmodule

`default_nettype wire
